[rtl/core/sgi_rle_row_decoder_defines.svh]
// ----------------------------------------------------------------------------
// SGI RLE row decoder assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SGI_RLE_ROW_DECODER_DEFINES_SVH
`define SGI_RLE_ROW_DECODER_DEFINES_SVH

// Property holds at every clock edge out of reset.
`define SRD_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("srd assertion failed");

// Antecedent implies consequent in the same cycle.
`define SRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srd assertion failed");

// Antecedent implies consequent in the next cycle.
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srd assertion failed");

`endif

[rtl/core/srd_pkg.sv]
// ----------------------------------------------------------------------------
// SGI RLE row decoder package
// Result type, decoder mode codes and fixed constants.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_CHANNEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH         = 1'b1;

    localparam logic [1:0]  BPC_RESET     = 2'd1;
    localparam logic [1:0]  BPC_WIDE      = 2'd2;
    localparam logic [15:0] ROW_WIDTH_RST = 16'd256;

    localparam logic [7:0] CTRL_LITERAL = 8'h80;
    localparam logic [6:0] RUN_MASK     = 7'h7F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [5:0] {
        MODE_DONE     = 6'b000001,
        MODE_CTRL     = 6'b000010,
        MODE_LIT      = 6'b000100,
        MODE_LIT_SKIP = 6'b001000,
        MODE_REP      = 6'b010000,
        MODE_REP_SKIP = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [6:0] run_length;
        logic       row_end;
        logic       short_row;
    } result_t;

endpackage

[rtl/core/srd_front.sv]
// ----------------------------------------------------------------------------
// SGI RLE row decoder front end
// Holds configuration, classifies each byte and tracks the row position.
// ----------------------------------------------------------------------------
module srd_front
    import srd_pkg::*;
#(
    parameter int WIDTH_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   in_fire,
    input  logic [7:0]             data_byte,
    input  logic                   row_start,
    output logic                   res_valid,
    output result_t                res
);

    logic [1:0]            bpc_reg;
    logic [15:0]           row_width_reg;
    mode_t                 mode_reg, mode_next, mode_cur;
    logic [6:0]            rem_reg, rem_next, rem_cur, rem_dec;
    logic [WIDTH_BITS-1:0] pw_reg, pw_next, pw_cur;
    logic [WIDTH_BITS-1:0] width_eff, diff, len_ext;
    logic                  room_zero, room_one, wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpc_reg       <= BPC_RESET;
            row_width_reg <= ROW_WIDTH_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BYTES_PER_CHANNEL: bpc_reg       <= wr_data[1:0];
                REG_ROW_WIDTH:         row_width_reg <= wr_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CTRL;
            rem_reg  <= '0;
            pw_reg   <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            rem_reg  <= rem_next;
            pw_reg   <= pw_next;
        end
    end

    always_comb
    begin
        wide      = (bpc_reg == BPC_WIDE);
        mode_cur  = row_start ? MODE_CTRL : mode_reg;
        rem_cur   = row_start ? 7'd0 : rem_reg;
        pw_cur    = row_start ? '0 : pw_reg;
        rem_dec   = rem_cur - 7'd1;
        width_eff = row_width_reg[WIDTH_BITS-1:0];
        diff      = width_eff - pw_cur;
        room_zero = (width_eff <= pw_cur);
        room_one  = !room_zero && (diff == {{(WIDTH_BITS-1){1'b0}}, 1'b1});
        len_ext   = {{(WIDTH_BITS-7){1'b0}}, rem_cur};

        mode_next = mode_reg;
        rem_next  = rem_reg;
        pw_next   = pw_reg;
        res_valid = 1'b0;
        res       = '0;

        if (in_fire)
        begin
            mode_next = mode_cur;
            rem_next  = rem_cur;
            pw_next   = pw_cur;
            case (mode_cur)
                MODE_CTRL:
                begin
                    if (room_zero)
                    begin
                        mode_next   = MODE_DONE;
                        res_valid   = 1'b1;
                        res.row_end = 1'b1;
                    end
                    else if (data_byte == 8'd0)
                    begin
                        mode_next     = MODE_DONE;
                        res_valid     = 1'b1;
                        res.row_end   = 1'b1;
                        res.short_row = 1'b1;
                    end
                    else if ((data_byte[6:0] & RUN_MASK) != 7'd0)
                    begin
                        rem_next  = data_byte[6:0];
                        mode_next = ((data_byte & CTRL_LITERAL) != 8'd0) ? MODE_LIT : MODE_REP;
                    end
                end
                MODE_LIT:
                begin
                    res_valid = 1'b1;
                    if (room_zero)
                    begin
                        mode_next   = MODE_DONE;
                        res.row_end = 1'b1;
                    end
                    else
                    begin
                        pw_next         = pw_cur + {{(WIDTH_BITS-1){1'b0}}, 1'b1};
                        rem_next        = rem_dec;
                        res.pixel_value = data_byte;
                        res.run_length  = 7'd1;
                        if (room_one)
                        begin
                            mode_next   = MODE_DONE;
                            res.row_end = 1'b1;
                        end
                        else if (wide)
                            mode_next = MODE_LIT_SKIP;
                        else
                            mode_next = (rem_dec == 7'd0) ? MODE_CTRL : MODE_LIT;
                    end
                end
                MODE_LIT_SKIP:
                    mode_next = (rem_cur == 7'd0) ? MODE_CTRL : MODE_LIT;
                MODE_REP:
                begin
                    res_valid = 1'b1;
                    if (room_zero)
                    begin
                        mode_next   = MODE_DONE;
                        res.row_end = 1'b1;
                    end
                    else
                    begin
                        rem_next        = 7'd0;
                        res.pixel_value = data_byte;
                        if (len_ext >= diff)
                        begin
                            pw_next        = width_eff;
                            mode_next      = MODE_DONE;
                            res.run_length = diff[6:0];
                            res.row_end    = 1'b1;
                        end
                        else
                        begin
                            pw_next        = pw_cur + len_ext;
                            mode_next      = wide ? MODE_REP_SKIP : MODE_CTRL;
                            res.run_length = rem_cur;
                        end
                    end
                end
                MODE_REP_SKIP:
                    mode_next = MODE_CTRL;
                MODE_DONE:
                    mode_next = MODE_DONE;
                default:
                    mode_next = MODE_DONE;
            endcase
        end
    end

endmodule

[rtl/core/srd_back.sv]
// ----------------------------------------------------------------------------
// SGI RLE row decoder back end
// Short result queue that presents the oldest request on the output side.
// ----------------------------------------------------------------------------
`include "sgi_rle_row_decoder_defines.svh"

module srd_back
    import srd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  result_t    wr_data,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] pixel_value,
    output logic [6:0] run_length,
    output logic       row_end,
    output logic       short_row
);

    result_t                q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_pop;
    result_t                head;

    assign full   = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = q_reg[rd_ptr_reg];

    assign pixel_value = head.pixel_value;
    assign run_length  = head.run_length;
    assign row_end     = head.row_end;
    assign short_row   = head.short_row;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (!wr && do_pop)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    `SRD_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `SRD_ASSERT_IMPL(a_no_write_full, clk, rst_n, wr, !full || do_pop)
    `SRD_ASSERT_NEXT(a_push_grows, clk, rst_n, wr && !do_pop, count_reg == $past(count_reg) + QUEUE_CNT_W'(1))
    `SRD_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, do_pop && !wr, count_reg == $past(count_reg) - QUEUE_CNT_W'(1))
    `SRD_ASSERT_ALWAYS(a_ptr_gap, clk, rst_n, (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0])

endmodule

[rtl/core/sgi_rle_row_decoder.sv]
// ----------------------------------------------------------------------------
// SGI RLE row decoder
// Decodes one channel row of SGI run-length data into (value, length) runs.
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  input     data_byte, row_start                          push / full
//  result    pixel_value, run_length, row_end, short_row   empty / pop
//  config    wr_index, wr_data                             wr_en
//
//  One byte is taken per cycle while full is low; its run is queued that cycle.
//  The front decode step updates mode, remaining run and row position per byte.
//  A four-entry result queue decouples output stalls from input acceptance.
//  full rises only when the queue holds four unread results.
//  Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module sgi_rle_row_decoder
    import srd_pkg::*;
#(
    parameter int WIDTH_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   row_start,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             pixel_value,
    output logic [6:0]             run_length,
    output logic                   row_end,
    output logic                   short_row
);

    logic    in_fire;
    logic    res_valid;
    result_t res;

    assign in_fire = push && !full;

    srd_front #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .row_start (row_start),
        .res_valid (res_valid),
        .res       (res)
    );

    srd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (res_valid),
        .wr_data     (res),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .pixel_value (pixel_value),
        .run_length  (run_length),
        .row_end     (row_end),
        .short_row   (short_row)
    );

endmodule

[sim/sgi_rle_row_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGI RLE row decoder testbench
// Feeds compressed row bytes through the push/full port and predicts every
// run in a cycle-free decoder model. Popped runs are compared field by field
// in order. Directed rows cover literals, replicates, clipping, 16-bit
// samples and the row-end markers. Random rows under random register
// settings follow, first without gaps, then with random stalls on both sides.
// ----------------------------------------------------------------------------
module sgi_rle_row_decoder_tb;
    import srd_pkg::*;

    localparam int IDLE_PCT     = 32;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 100;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index  = '0;
    logic [CFG_DATA_W-1:0]  wr_data   = '0;
    logic                   push      = 1'b0;
    logic                   full;
    logic [7:0]             data_byte = 8'd0;
    logic                   row_start = 1'b0;
    logic                   empty;
    logic                   pop       = 1'b0;
    logic [7:0]             pixel_value;
    logic [6:0]             run_length;
    logic                   row_end;
    logic                   short_row;

    logic [1:0]  cfg_bpc;
    logic [15:0] cfg_width;
    mode_t       dec_mode;
    logic [6:0]  run_left;
    logic [15:0] pix_count;

    result_t pending_runs[$];
    int      mismatches    = 0;
    int      decoded_bytes = 0;
    int      quiet_cycles  = 0;
    logic    steady        = 1'b0;

    sgi_rle_row_decoder #(
        .WIDTH_BITS(16)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .row_start  (row_start),
        .empty      (empty),
        .pop        (pop),
        .pixel_value(pixel_value),
        .run_length (run_length),
        .row_end    (row_end),
        .short_row  (short_row)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic logic decode_byte(input logic [7:0] b, input logic rs,
                                         output result_t run);
        logic        wide;
        logic        has_run;
        logic [15:0] room;
        logic [6:0]  len;
        wide    = (cfg_bpc == BPC_WIDE);
        has_run = 1'b0;
        run     = '0;
        if (rs)
        begin
            dec_mode  = MODE_CTRL;
            run_left  = 7'd0;
            pix_count = 16'd0;
        end
        room = (cfg_width > pix_count) ? cfg_width - pix_count : 16'd0;
        case (dec_mode)
            MODE_CTRL:
            begin
                len = b[6:0] & RUN_MASK;
                if (room == 16'd0)
                begin
                    dec_mode    = MODE_DONE;
                    run.row_end = 1'b1;
                    has_run     = 1'b1;
                end
                else if (b == 8'd0)
                begin
                    dec_mode      = MODE_DONE;
                    run.row_end   = 1'b1;
                    run.short_row = 1'b1;
                    has_run       = 1'b1;
                end
                else if (len != 7'd0)
                begin
                    run_left = len;
                    dec_mode = ((b & CTRL_LITERAL) != 8'd0) ? MODE_LIT : MODE_REP;
                end
            end
            MODE_LIT:
            begin
                has_run = 1'b1;
                if (room == 16'd0)
                begin
                    dec_mode    = MODE_DONE;
                    run.row_end = 1'b1;
                end
                else
                begin
                    pix_count       = pix_count + 16'd1;
                    run_left        = run_left - 7'd1;
                    run.pixel_value = b;
                    run.run_length  = 7'd1;
                    if (room == 16'd1)
                    begin
                        dec_mode    = MODE_DONE;
                        run.row_end = 1'b1;
                    end
                    else if (wide)
                        dec_mode = MODE_LIT_SKIP;
                    else
                        dec_mode = (run_left == 7'd0) ? MODE_CTRL : MODE_LIT;
                end
            end
            MODE_LIT_SKIP:
                dec_mode = (run_left == 7'd0) ? MODE_CTRL : MODE_LIT;
            MODE_REP:
            begin
                has_run = 1'b1;
                if (room == 16'd0)
                begin
                    dec_mode    = MODE_DONE;
                    run.row_end = 1'b1;
                end
                else
                begin
                    len             = run_left;
                    run_left        = 7'd0;
                    run.pixel_value = b;
                    if ({9'd0, len} >= room)
                    begin
                        pix_count      = pix_count + room;
                        dec_mode       = MODE_DONE;
                        run.run_length = room[6:0];
                        run.row_end    = 1'b1;
                    end
                    else
                    begin
                        pix_count      = pix_count + {9'd0, len};
                        dec_mode       = wide ? MODE_REP_SKIP : MODE_CTRL;
                        run.run_length = len;
                    end
                end
            end
            MODE_REP_SKIP:
                dec_mode = MODE_CTRL;
            default:
                dec_mode = MODE_DONE;
        endcase
        return has_run;
    endfunction

    always @(negedge clk)
        pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin : check_runs
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_runs.size() == 0)
                note_mismatch("unexpected run, pixel_value", pixel_value, 0);
            else
            begin
                want = pending_runs.pop_front();
                if (pixel_value !== want.pixel_value)
                    note_mismatch("pixel_value", pixel_value, want.pixel_value);
                if (run_length !== want.run_length)
                    note_mismatch("run_length", run_length, want.run_length);
                if (row_end !== want.row_end)
                    note_mismatch("row_end", row_end, want.row_end);
                if (short_row !== want.short_row)
                    note_mismatch("short_row", short_row, want.short_row);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ERROR: no request moved for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic rs);
        result_t run;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push      <= 1'b1;
        data_byte <= b;
        row_start <= rs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decoded_bytes++;
        if (decode_byte(b, rs, run))
            pending_runs.push_back(run);
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == REG_BYTES_PER_CHANNEL)
            cfg_bpc = val[1:0];
        else
            cfg_width = val;
    endtask

    function automatic logic [6:0] pick_run_len();
        return ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom_range(1, 12));
    endfunction

    function automatic logic [15:0] pick_row_width();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            return 16'd1;
        else if (pick == 1)
            return 16'hFFFF;
        else if (pick == 2)
            return 16'd0;
        else if (pick == 3)
            return 16'($urandom_range(128, 65534));
        return 16'($urandom_range(2, 48));
    endfunction

    task automatic send_row();
        logic [7:0] ctrl;
        logic [6:0] len;
        int         packets;
        int         samples;
        int         pick;
        int         k;
        int         s;
        packets = $urandom_range(1, 6);
        for (k = 0; k < packets; k++)
        begin
            if (k > 0 && dec_mode == MODE_DONE)
                break;
            pick = $urandom_range(0, 19);
            len  = pick_run_len();
            if (pick == 0)
            begin
                ctrl    = 8'h00;
                samples = 0;
            end
            else if (pick == 1)
            begin
                ctrl    = CTRL_LITERAL;
                samples = 0;
            end
            else if (pick <= 10)
            begin
                ctrl    = CTRL_LITERAL | {1'b0, len};
                samples = len;
            end
            else
            begin
                ctrl    = {1'b0, len};
                samples = 1;
            end
            send_byte(ctrl, k == 0);
            for (s = 0; s < samples; s++)
            begin
                if (dec_mode == MODE_DONE)
                    break;
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                if (cfg_bpc == BPC_WIDE)
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    task automatic test_literal_replicate();
        send_byte(8'h83, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(CTRL_LITERAL, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
    endtask

    task automatic test_clipping();
        settle();
        write_reg(REG_ROW_WIDTH, 16'd3);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hEE, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
    endtask

    task automatic test_wide_samples();
        settle();
        write_reg(REG_BYTES_PER_CHANNEL, {14'd0, BPC_WIDE});
        write_reg(REG_ROW_WIDTH, 16'd4);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC1, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hD0, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_full_row_markers();
        settle();
        write_reg(REG_BYTES_PER_CHANNEL, 16'd0);
        write_reg(REG_ROW_WIDTH, 16'd0);
        send_byte(8'h00, 1'b1);
        settle();
        write_reg(REG_ROW_WIDTH, 16'hFFFF);
        send_byte(8'h84, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        settle();
        write_reg(REG_ROW_WIDTH, 16'd2);
        send_byte(8'h33, 1'b0);
    endtask

    task automatic test_random_traffic(input int target, input logic no_gaps);
        int start;
        start  = decoded_bytes;
        steady = no_gaps;
        while (decoded_bytes - start < target)
        begin
            settle();
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_BYTES_PER_CHANNEL, {14'd0, BPC_WIDE});
            else
                write_reg(REG_BYTES_PER_CHANNEL, 16'($urandom_range(0, 3)));
            write_reg(REG_ROW_WIDTH, pick_row_width());
            repeat ($urandom_range(3, 10))
            begin
                if (decoded_bytes - start >= target)
                    break;
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_row();
            end
        end
        settle();
        steady = 1'b0;
    endtask

    initial
    begin
        cfg_bpc   = BPC_RESET;
        cfg_width = ROW_WIDTH_RST;
        dec_mode  = MODE_CTRL;
        run_left  = 7'd0;
        pix_count = 16'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_literal_replicate();
        test_clipping();
        test_wide_samples();
        test_full_row_markers();
        test_random_traffic(300, 1'b1);
        test_random_traffic(1120, 1'b0);

        settle();
        if (mismatches == 0 && pending_runs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
